// ----- rtl/core/rvce_pkg.sv -----
// Shared types, constants and codes for the reduced-volume coupling energy block.
package rvce_pkg;

  localparam int unsigned WW = 128;

  localparam logic [35:0] KC_Q32 = 36'd45675787940;
  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [62:0] Q_CLAMP = {1'b1, 62'd0};

  localparam logic [7:0] MUL_STEPS = 8'd64;
  localparam logic [7:0] DIV_STEPS = 8'd128;
  localparam logic [7:0] SQRT_STEPS = 8'd64;

  typedef enum logic [1:0] {
    CMD_EVAL  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PRESSURE = 2'd0,
    REG_STIFF    = 2'd1,
    REG_TARGET   = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2,
    ALU_NOP  = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQRT,
    ST_PMUL,
    ST_NMUL,
    ST_DIV,
    ST_DSQ,
    ST_KMUL,
    ST_PMAG,
    ST_ENERGY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [46:0]        old_area;
    logic signed [47:0] old_volume;
    logic [46:0]        new_area;
    logic signed [47:0] new_volume;
  } in_t;

  typedef struct packed {
    logic signed [63:0] energy_change;
    logic signed [63:0] coupling_energy;
    logic               area_fault;
  } out_t;

endpackage

// ----- rtl/core/rvce_alu.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
module rvce_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rvce_pkg::alu_req_t       req,
  input  logic [rvce_pkg::WW-1:0]  opa,
  input  logic [rvce_pkg::WW-1:0]  opb,
  output logic                     done,
  output logic [rvce_pkg::WW-1:0]  res
);

  logic                    busy_r;
  logic                    done_r;
  rvce_pkg::alu_op_t       op_r;
  logic [7:0]              cnt_r;
  logic [rvce_pkg::WW-1:0] acc_r;
  logic [rvce_pkg::WW-1:0] a_r;
  logic [rvce_pkg::WW-1:0] b_r;

  logic [rvce_pkg::WW-1:0] mul_sum;
  logic [rvce_pkg::WW-1:0] div_r2;
  logic                    div_ge;
  logic [rvce_pkg::WW-1:0] sq_r2;
  logic [rvce_pkg::WW-1:0] sq_tr;
  logic                    sq_ge;

  assign mul_sum = acc_r + a_r;
  assign div_r2  = {acc_r[rvce_pkg::WW-2:0], a_r[rvce_pkg::WW-1]};
  assign div_ge  = div_r2 >= b_r;
  assign sq_r2   = {acc_r[rvce_pkg::WW-3:0], a_r[rvce_pkg::WW-1:rvce_pkg::WW-2]};
  assign sq_tr   = {b_r[rvce_pkg::WW-3:0], 2'b01};
  assign sq_ge   = sq_r2 >= sq_tr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= rvce_pkg::ALU_NOP;
      cnt_r  <= 8'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        case (req.op)
          rvce_pkg::ALU_DIV:  cnt_r <= rvce_pkg::DIV_STEPS;
          rvce_pkg::ALU_SQRT: cnt_r <= rvce_pkg::SQRT_STEPS;
          default:            cnt_r <= rvce_pkg::MUL_STEPS;
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= opa;
      b_r   <= opb;
    end else if (busy_r) begin
      case (op_r)
        rvce_pkg::ALU_MUL: begin
          if (b_r[0]) acc_r <= mul_sum;
          a_r <= {a_r[rvce_pkg::WW-2:0], 1'b0};
          b_r <= {1'b0, b_r[rvce_pkg::WW-1:1]};
        end
        rvce_pkg::ALU_DIV: begin
          acc_r <= div_ge ? div_r2 - b_r : div_r2;
          a_r   <= {a_r[rvce_pkg::WW-2:0], div_ge};
        end
        rvce_pkg::ALU_SQRT: begin
          acc_r <= sq_ge ? sq_r2 - sq_tr : sq_r2;
          a_r   <= {a_r[rvce_pkg::WW-3:0], 2'b00};
          b_r   <= {b_r[rvce_pkg::WW-2:0], sq_ge};
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  always_comb begin
    case (op_r)
      rvce_pkg::ALU_DIV:  res = a_r;
      rvce_pkg::ALU_SQRT: res = b_r;
      default:            res = acc_r;
    endcase
  end

  assign done = done_r;

endmodule

// ----- rtl/core/reduced_volume_coupling_energy.sv -----
// Top level: totals, configuration, energy sequencer around the shared unit.
//
//  channel | signals                        | transfer
//  in      | in_valid, in_ready, in_data    | valid & ready
//  out     | out_valid, out_ready, out_data | valid & ready
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
//  One energy runs a square root (64 steps), five multiplies (64 steps each) and
//  one divide (128 steps) on the one shared unit, then combines the terms.
//  Evaluate needs two energies when the proposed area is positive, else one;
//  commit and no-op need one; clear, or a non-positive current area, needs none.
//  Synchronous active-low reset clears totals and config registers; in_ready is low
//  from accept until the result is loaded into the output register.
module reduced_volume_coupling_energy (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvce_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvce_pkg::out_t     out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x[49:47] == 3'b000 || x[49:47] == 3'b111) return x[47:0];
    return x[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  function automatic logic signed [63:0] satsub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] == d[63]) return d[63:0];
    return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  rvce_pkg::state_t   state_r, state_nxt;
  logic signed [47:0] dp_r;
  logic [46:0]        kv_r;
  logic [46:0]        v0_r;
  logic signed [47:0] tot_vol_r, tot_area_r;
  logic signed [47:0] pv_r, pa_r;
  logic [1:0]         cmd_r;
  logic               pass_r;
  logic               issued_r;
  logic               fault_r;
  logic signed [63:0] ecur_r, change_r;
  logic [62:0]        kterm_r;
  logic signed [63:0] pterm_r;
  logic [127:0]       t1_r, p_r;
  logic               out_valid_r;
  rvce_pkg::out_t     out_data_r;

  logic               accept;
  logic signed [48:0] dv;
  logic signed [47:0] da;
  logic signed [47:0] pv_in, pa_in;
  logic signed [47:0] cur_vol, cur_area;
  logic [47:0]        vmag, pmag;
  logic               q_big;
  logic [62:0]        qm;
  logic signed [63:0] vq, dd;
  logic [63:0]        dm;
  logic [62:0]        kterm_new, pm;
  logic signed [63:0] e_now;
  rvce_pkg::alu_req_t req;
  logic [127:0]       opa, opb, res;
  logic               alu_done;
  logic               busy_st;

  assign accept = in_valid && in_ready;
  assign dv = {in_data.new_volume[47], in_data.new_volume}
            - {in_data.old_volume[47], in_data.old_volume};
  assign da = $signed({1'b0, in_data.new_area}) - $signed({1'b0, in_data.old_area});
  assign pv_in = sat48({tot_vol_r[47], tot_vol_r[47], tot_vol_r} + {dv[48], dv});
  assign pa_in = sat48({{2{tot_area_r[47]}}, tot_area_r} + {{2{da[47]}}, da});

  assign cur_vol  = pass_r ? pv_r : tot_vol_r;
  assign cur_area = pass_r ? pa_r : tot_area_r;
  assign vmag = cur_vol[47] ? 48'(-cur_vol) : 48'(cur_vol);
  assign pmag = dp_r[47] ? 48'(-dp_r) : 48'(dp_r);

  assign q_big = (t1_r[127:63] != '0) || (t1_r[62] && (t1_r[61:0] != '0));
  assign qm = q_big ? rvce_pkg::Q_CLAMP : t1_r[62:0];
  assign vq = cur_vol[47] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  assign dd = vq - $signed({17'd0, v0_r});
  assign dm = dd[63] ? 64'(-dd) : 64'(dd);

  assign kterm_new = (t1_r[127:88] != '0) ? ((kv_r != '0) ? rvce_pkg::MAX63 : 63'd0)
                   : ((res[127:87] != '0) ? rvce_pkg::MAX63 : res[86:24]);
  assign pm = (res[127:87] != '0) ? rvce_pkg::MAX63 : res[86:24];
  assign e_now = satsub($signed({1'b0, kterm_r}), pterm_r);

  assign busy_st = (state_r == rvce_pkg::ST_SQRT) || (state_r == rvce_pkg::ST_PMUL)
                || (state_r == rvce_pkg::ST_NMUL) || (state_r == rvce_pkg::ST_DIV)
                || (state_r == rvce_pkg::ST_DSQ)  || (state_r == rvce_pkg::ST_KMUL)
                || (state_r == rvce_pkg::ST_PMAG);

  always_comb begin
    state_nxt = state_r;
    req.start = busy_st && !issued_r;
    req.op    = rvce_pkg::ALU_MUL;
    opa       = '0;
    opb       = '0;
    case (state_r)
      rvce_pkg::ST_IDLE:  if (accept) state_nxt = rvce_pkg::ST_CHECK;
      rvce_pkg::ST_CHECK: begin
        if (!tot_area_r[47] && tot_area_r != '0) state_nxt = rvce_pkg::ST_SQRT;
        else state_nxt = rvce_pkg::ST_OUT;
      end
      rvce_pkg::ST_SQRT: begin
        req.op = rvce_pkg::ALU_SQRT;
        opa = {57'd0, cur_area[46:0], 24'd0};
        if (alu_done) state_nxt = rvce_pkg::ST_PMUL;
      end
      rvce_pkg::ST_PMUL: begin
        opa = {81'd0, cur_area[46:0]};
        opb = t1_r;
        if (alu_done) state_nxt = rvce_pkg::ST_NMUL;
      end
      rvce_pkg::ST_NMUL: begin
        opa = {80'd0, vmag};
        opb = {92'd0, rvce_pkg::KC_Q32};
        if (alu_done) state_nxt = rvce_pkg::ST_DIV;
      end
      rvce_pkg::ST_DIV: begin
        req.op = rvce_pkg::ALU_DIV;
        opa = {t1_r[111:0], 16'd0};
        opb = p_r;
        if (alu_done) state_nxt = rvce_pkg::ST_DSQ;
      end
      rvce_pkg::ST_DSQ: begin
        opa = {64'd0, dm};
        opb = {64'd0, dm};
        if (alu_done) state_nxt = rvce_pkg::ST_KMUL;
      end
      rvce_pkg::ST_KMUL: begin
        opa = {64'd0, t1_r[87:24]};
        opb = {81'd0, kv_r};
        if (alu_done) state_nxt = rvce_pkg::ST_PMAG;
      end
      rvce_pkg::ST_PMAG: begin
        opa = {80'd0, pmag};
        opb = {80'd0, vmag};
        if (alu_done) state_nxt = rvce_pkg::ST_ENERGY;
      end
      rvce_pkg::ST_ENERGY: begin
        if (!pass_r && cmd_r == rvce_pkg::CMD_EVAL && !pa_r[47] && pa_r != '0)
          state_nxt = rvce_pkg::ST_SQRT;
        else state_nxt = rvce_pkg::ST_OUT;
      end
      rvce_pkg::ST_OUT: if (!out_valid_r || out_ready) state_nxt = rvce_pkg::ST_IDLE;
      default: state_nxt = rvce_pkg::ST_IDLE;
    endcase
  end

  rvce_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .done  (alu_done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rvce_pkg::ST_IDLE;
      dp_r        <= '0;
      kv_r        <= '0;
      v0_r        <= '0;
      tot_vol_r   <= '0;
      tot_area_r  <= '0;
      issued_r    <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rvce_pkg::REG_PRESSURE: dp_r <= cfg_data;
          rvce_pkg::REG_STIFF:    kv_r <= cfg_data[46:0];
          rvce_pkg::REG_TARGET:   v0_r <= cfg_data[46:0];
          default:                dp_r <= dp_r;
        endcase
      end
      if (req.start) issued_r <= 1'b1;
      else if (alu_done) issued_r <= 1'b0;
      if (state_r == rvce_pkg::ST_OUT && state_nxt == rvce_pkg::ST_IDLE) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        rvce_pkg::ST_IDLE: begin
          if (accept) begin
            pass_r <= 1'b0;
            if (in_data.command == rvce_pkg::CMD_COMMIT) begin
              tot_vol_r  <= pv_in;
              tot_area_r <= pa_in;
            end else if (in_data.command == rvce_pkg::CMD_CLEAR) begin
              tot_vol_r  <= '0;
              tot_area_r <= '0;
            end
          end
        end
        rvce_pkg::ST_ENERGY: if (state_nxt == rvce_pkg::ST_SQRT) pass_r <= 1'b1;
        default: pass_r <= pass_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data.command;
      pv_r    <= pv_in;
      pa_r    <= pa_in;
      fault_r <= 1'b0;
    end
    case (state_r)
      rvce_pkg::ST_CHECK: begin
        change_r <= '0;
        ecur_r   <= '0;
        if (state_nxt == rvce_pkg::ST_OUT) fault_r <= 1'b1;
      end
      rvce_pkg::ST_SQRT, rvce_pkg::ST_NMUL, rvce_pkg::ST_DIV, rvce_pkg::ST_DSQ:
        if (alu_done) t1_r <= res;
      rvce_pkg::ST_PMUL: if (alu_done) p_r <= res;
      rvce_pkg::ST_KMUL: if (alu_done) kterm_r <= kterm_new;
      rvce_pkg::ST_PMAG: begin
        if (alu_done)
          pterm_r <= (dp_r[47] != cur_vol[47]) ? -$signed({1'b0, pm})
                                               : $signed({1'b0, pm});
      end
      rvce_pkg::ST_ENERGY: begin
        if (!pass_r) begin
          ecur_r <= e_now;
          if (cmd_r == rvce_pkg::CMD_EVAL && state_nxt == rvce_pkg::ST_OUT)
            fault_r <= 1'b1;
        end else begin
          change_r <= satsub(e_now, ecur_r);
        end
      end
      rvce_pkg::ST_OUT: begin
        if (state_nxt == rvce_pkg::ST_IDLE) begin
          out_data_r.energy_change   <= change_r;
          out_data_r.coupling_energy <= ecur_r;
          out_data_r.area_fault      <= fault_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == rvce_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/rvce_chk.sv -----
// Port-level checker for the reduced-volume coupling energy block, with its bind.
module rvce_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input rvce_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input rvce_pkg::out_t out_data,
  input logic           cfg_we,
  input logic [1:0]     cfg_index,
  input logic [47:0]    cfg_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while busy");

  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.area_fault && (out_data.coupling_energy != 64'sd0)
    |-> out_data.energy_change == 64'sd0)
    else $error("energy change reported with an area fault");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind reduced_volume_coupling_energy rvce_chk u_rvce_chk (.*);
